/* sv/rxbw_pkg.sv */
// rxbw_pkg: shared types and constants of the receive byte window.
// Fixed field widths, item kinds and the matcher control group.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rxbw_pkg;

	localparam int DEF_WINDOW_DEPTH    = 1024;
	localparam int DEF_MAX_TOKEN_BYTES = 8;

	localparam int KIND_W      = 2;
	localparam int BYTE_W      = 8;
	localparam int DISC_W      = 16;
	localparam int TOKEN_W     = 64;
	localparam int LEN_W       = 4;
	localparam int COUNT_OUT_W = 11;
	localparam int TOK_IDX_W   = $clog2(TOKEN_W / BYTE_W);

	typedef enum logic [KIND_W-1:0] {
		KIND_PUSH    = 2'd0,
		KIND_DISCARD = 2'd1,
		KIND_CLEAR   = 2'd2,
		KIND_SEARCH  = 2'd3
	} rxbw_kind_t;

	// Result held between the sequencer and the output register
	typedef struct packed {
		logic                   found;
		logic [COUNT_OUT_W-1:0] stored_count;
		logic                   dropped;
	} rxbw_res_t;

	// Control from the sequencer to the token matcher
	typedef struct packed {
		logic start;
		logic shift;
	} rxbw_mctl_t;

endpackage

`default_nettype wire

/* sv/rxbw_if.sv */
// rxbw_if: valid/ready channels of the receive byte window.
// Item channel carries the request fields, result channel the response.
// Depends on rxbw_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface rxbw_item_if;
	import rxbw_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [KIND_W-1:0]    kind;
	logic [BYTE_W-1:0]    data_byte;
	logic [DISC_W-1:0]    discard_count;
	logic [TOKEN_W-1:0]   token_bytes;
	logic [LEN_W-1:0]     token_length;

	modport source (output valid, kind, data_byte, discard_count, token_bytes, token_length,
		input ready);
	modport sink (input valid, kind, data_byte, discard_count, token_bytes, token_length,
		output ready);
endinterface

interface rxbw_result_if;
	import rxbw_pkg::*;

	logic                   valid;
	logic                   ready;
	logic                   found;
	logic [COUNT_OUT_W-1:0] stored_count;
	logic                   dropped_oldest;

	modport source (output valid, found, stored_count, dropped_oldest, input ready);
	modport sink (input valid, found, stored_count, dropped_oldest, output ready);
endinterface

`default_nettype wire

/* sv/rxbw_ram.sv */
// rxbw_ram: byte store of the receive window, one write and one read port.
// Read data is registered. No reset: entries are read only after written.
// Depends on rxbw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rxbw_ram #(
	parameter int DEPTH = rxbw_pkg::DEF_WINDOW_DEPTH,
	parameter int AW    = $clog2(rxbw_pkg::DEF_WINDOW_DEPTH)
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [rxbw_pkg::BYTE_W-1:0] wdata,
	input  logic                      re,
	input  logic [AW-1:0]             raddr,
	output logic [rxbw_pkg::BYTE_W-1:0] rdata
);
	import rxbw_pkg::*;

	logic [BYTE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* sv/rxbw_match.sv */
// rxbw_match: token comparator shared by every scan position.
// Holds the last few scanned bytes and the reversed token, flags a hit.
// Depends on rxbw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rxbw_match #(
	parameter int MAX_TOKEN_BYTES = rxbw_pkg::DEF_MAX_TOKEN_BYTES
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rxbw_pkg::rxbw_mctl_t         ctl,
	input  logic [rxbw_pkg::BYTE_W-1:0]  byte_in,
	input  logic [rxbw_pkg::TOKEN_W-1:0] token_bytes,
	input  logic [rxbw_pkg::LEN_W-1:0]   token_length,
	output logic                         hit
);
	import rxbw_pkg::*;

	logic [BYTE_W-1:0]    hist_q [MAX_TOKEN_BYTES];
	logic [BYTE_W-1:0]    tok_q  [MAX_TOKEN_BYTES];
	logic [BYTE_W-1:0]    tok_rev [MAX_TOKEN_BYTES];
	logic [LEN_W-1:0]     len_q;
	logic [LEN_W-1:0]     fill_q;
	logic [MAX_TOKEN_BYTES-1:0] eq;

	// Newest byte sits in slot 0, so slot j pairs with token byte len-1-j
	always_comb begin
		logic [LEN_W-1:0] idx;
		for (int j = 0; j < MAX_TOKEN_BYTES; j++) begin
			idx = token_length - LEN_W'(1) - LEN_W'(j);
			tok_rev[j] = token_bytes[BYTE_W*idx[TOK_IDX_W-1:0] +: BYTE_W];
		end
	end

	always_comb begin
		for (int j = 0; j < MAX_TOKEN_BYTES; j++) begin
			eq[j] = (LEN_W'(j) >= len_q) || (hist_q[j] == tok_q[j]);
		end
	end

	assign hit = (len_q != '0) && (fill_q == len_q) && (&eq);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			fill_q <= '0;
		end else if (ctl.start) begin
			len_q  <= token_length;
			fill_q <= '0;
		end else if (ctl.shift && fill_q != len_q) begin
			fill_q <= fill_q + LEN_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			tok_q <= tok_rev;
		end else if (ctl.shift) begin
			hist_q[0] <= byte_in;
			for (int j = 1; j < MAX_TOKEN_BYTES; j++) begin
				hist_q[j] <= hist_q[j-1];
			end
		end
	end

endmodule

`default_nettype wire

/* sv/rx_byte_window_token_search.sv */
// rx_byte_window_token_search: bounded receive byte window with token search.
// Push, discard and clear update the window on accept; the result goes through the
// pending and output registers, and such items can follow each other every cycle
// while results are taken. A search streams the stored bytes through the one RAM
// read port into the shared comparator, one byte a cycle, ending early on a hit.
// Reset empties the window at once; the byte store itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module rx_byte_window_token_search #(
	parameter int WINDOW_DEPTH    = rxbw_pkg::DEF_WINDOW_DEPTH,
	parameter int MAX_TOKEN_BYTES = rxbw_pkg::DEF_MAX_TOKEN_BYTES
) (
	input  logic           clk,
	input  logic           arst_n,
	rxbw_item_if.sink      item,
	rxbw_result_if.source  result
);
	import rxbw_pkg::*;

	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam int CW = $clog2(WINDOW_DEPTH + 1);
	localparam int XW = (CW > DISC_W) ? CW : DISC_W;
	localparam logic [AW:0]   DEPTH_S = (AW+1)'(WINDOW_DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(WINDOW_DEPTH);

	typedef enum logic {ST_IDLE, ST_SCAN} state_t;

	state_t           state_q;
	logic [AW-1:0]    front_q;
	logic [CW-1:0]    count_q;
	logic [AW-1:0]    rd_pos_q;
	logic [CW-1:0]    left_q;
	logic             rd_vld_s1;
	logic             pend_vld_q;
	rxbw_res_t        pend_q;
	logic             res_vld_q;
	rxbw_res_t        res_q;

	logic             accept;
	logic             pend_move;
	rxbw_kind_t       kind;
	logic             full;
	logic             disc_all;
	logic             tok_bad;
	logic             start_scan;
	logic             scan_done;
	logic             hit;
	logic [AW:0]      tail_sum;
	logic [AW:0]      front_inc_sum;
	logic [AW:0]      disc_sum;
	logic [AW:0]      rd_sum;
	logic [AW-1:0]    nxt_front;
	logic [CW-1:0]    nxt_count;
	logic             nxt_drop;
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic             ram_re;
	logic [BYTE_W-1:0] ram_rdata;
	rxbw_mctl_t       mctl;

	function automatic logic [AW-1:0] ring_wrap(input logic [AW:0] a);
		logic [AW:0] r;
		r = (a >= DEPTH_S) ? a - DEPTH_S : a;
		return r[AW-1:0];
	endfunction

	assign kind       = rxbw_kind_t'(item.kind);
	assign accept     = item.valid && item.ready;
	assign pend_move  = pend_vld_q && (!res_vld_q || result.ready);
	assign item.ready = (state_q == ST_IDLE) && (!pend_vld_q || pend_move);

	assign full          = (count_q == DEPTH_C);
	assign tail_sum      = {1'b0, front_q} + (AW+1)'(count_q);
	assign front_inc_sum = {1'b0, front_q} + (AW+1)'(1);
	assign disc_sum      = {1'b0, front_q} + (AW+1)'(item.discard_count);
	assign rd_sum        = {1'b0, rd_pos_q} + (AW+1)'(1);
	assign disc_all      = XW'(item.discard_count) >= XW'(count_q);
	assign tok_bad       = (item.token_length == '0)
		|| (32'(item.token_length) > 32'(MAX_TOKEN_BYTES))
		|| (XW'(item.token_length) > XW'(count_q));

	assign start_scan = accept && (kind == KIND_SEARCH) && !tok_bad;
	assign scan_done  = hit || (left_q == '0 && !rd_vld_s1);

	always_comb begin
		nxt_front = front_q;
		nxt_count = count_q;
		nxt_drop  = 1'b0;
		unique case (kind)
			KIND_PUSH: begin
				if (full) begin
					nxt_front = ring_wrap(front_inc_sum);
					nxt_drop  = 1'b1;
				end else begin
					nxt_count = count_q + CW'(1);
				end
			end
			KIND_DISCARD: begin
				if (disc_all) begin
					nxt_count = '0;
				end else begin
					nxt_front = ring_wrap(disc_sum);
					nxt_count = count_q - CW'(item.discard_count);
				end
			end
			KIND_CLEAR: begin
				nxt_front = '0;
				nxt_count = '0;
			end
			KIND_SEARCH: begin
			end
		endcase
	end

	// On a full window the new byte overwrites the oldest one
	assign ram_we    = accept && (kind == KIND_PUSH);
	assign ram_waddr = full ? front_q : ring_wrap(tail_sum);
	assign ram_re    = (state_q == ST_SCAN) && (left_q != '0);

	assign mctl.start = start_scan;
	assign mctl.shift = rd_vld_s1;

	rxbw_ram #(
		.DEPTH (WINDOW_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (item.data_byte),
		.re    (ram_re),
		.raddr (rd_pos_q),
		.rdata (ram_rdata)
	);

	rxbw_match #(
		.MAX_TOKEN_BYTES (MAX_TOKEN_BYTES)
	) u_match (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (mctl),
		.byte_in      (ram_rdata),
		.token_bytes  (item.token_bytes),
		.token_length (item.token_length),
		.hit          (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			front_q    <= '0;
			count_q    <= '0;
			rd_pos_q   <= '0;
			left_q     <= '0;
			rd_vld_s1  <= 1'b0;
			pend_vld_q <= 1'b0;
			pend_q     <= '0;
			res_vld_q  <= 1'b0;
			res_q      <= '0;
		end else begin
			rd_vld_s1 <= ram_re;

			// Advance the pending result into the output register
			if (pend_move) begin
				res_vld_q <= 1'b1;
				res_q     <= pend_q;
			end else if (result.ready) begin
				res_vld_q <= 1'b0;
			end

			// Hold a pending result until the output register takes it
			if (accept) begin
				pend_vld_q <= !start_scan;
			end else if (state_q == ST_SCAN && scan_done) begin
				pend_vld_q <= 1'b1;
			end else if (pend_move) begin
				pend_vld_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						front_q <= nxt_front;
						count_q <= nxt_count;
						pend_q.found        <= 1'b0;
						pend_q.stored_count <= COUNT_OUT_W'(nxt_count);
						pend_q.dropped      <= nxt_drop;
						if (start_scan) begin
							state_q  <= ST_SCAN;
							rd_pos_q <= front_q;
							left_q   <= count_q;
						end
					end
				end
				ST_SCAN: begin
					if (left_q != '0) begin
						rd_pos_q <= ring_wrap(rd_sum);
						left_q   <= left_q - CW'(1);
					end
					if (scan_done) begin
						state_q      <= ST_IDLE;
						pend_q.found <= hit;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result.valid          = res_vld_q;
	assign result.found          = res_q.found;
	assign result.stored_count   = res_q.stored_count;
	assign result.dropped_oldest = res_q.dropped;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C && front_q <= AW'(WINDOW_DEPTH - 1))
		else $error("window count or front out of range");

	a_scan_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> !pend_vld_q)
		else $error("pending result present during scan");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		pend_vld_q && pend_q.dropped |-> count_q == DEPTH_C)
		else $error("dropped flag without a full window");

	a_scan_reads: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |=> left_q < $past(left_q))
		else $error("scan read without progress");

endmodule

`default_nettype wire
